// ===== hdl/write_through_associative_cache_top_defines.svh =====
// Assertion macros shared by the cache controller and datapath.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef WRITE_THROUGH_ASSOCIATIVE_CACHE_TOP_DEFINES_SVH
`define WRITE_THROUGH_ASSOCIATIVE_CACHE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WTAC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WTAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/wtac_pkg.sv =====
// Shared types and constants for the write-through associative cache.
// Used by wtac_ctrl, wtac_dp and the top level; depends on nothing.
`timescale 1ns / 1ps

package wtac_pkg;

  localparam int ADDR_W  = 10;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = 32;
  localparam int ENTRIES = 8;
  localparam int PTR_W   = $clog2(ENTRIES);
  // The backing memory covers the whole word address space.
  localparam int MEM_AW    = ADDR_W;
  localparam int MEM_WORDS = 2 ** MEM_AW;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_STORE = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // take the request and start the memory read
    logic commit;    // resolve the lookup and update all state
    logic clear_en;  // write zero at the sweep address
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;  // sweep address is on the last memory word
    logic out_stall;   // result register full and not being taken
  } ctrl_sts_t;

endpackage

// ===== hdl/wtac_ctrl.sv =====
// Controller state machine for the write-through associative cache.
// Depends on wtac_pkg and the shared assertion macro header.
`timescale 1ns / 1ps
`include "write_through_associative_cache_top_defines.svh"

module wtac_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  wtac_pkg::ctrl_sts_t sts,
  output wtac_pkg::ctrl_cmd_t cmd
);
  import wtac_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sts.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (!sts.out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.capture  = 1'b0;
    cmd.commit   = 1'b0;
    cmd.clear_en = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
      end
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_LOOKUP: begin
        cmd.commit = !sts.out_stall;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  `WTAC_ASSERT_NEXT(a_capture_to_lookup, cmd.capture, state == ST_LOOKUP, "capture did not start a lookup")
  `WTAC_ASSERT_NEXT(a_commit_frees_input, cmd.commit, in_ready, "input not ready after a commit")
  `WTAC_ASSERT_NEXT(a_clear_holds, state == ST_CLEAR && !sts.clear_last, state == ST_CLEAR && !in_ready, "clearing sweep ended early")

endmodule

// ===== hdl/wtac_dp.sv =====
// Datapath of the write-through associative cache: entry array, replacement
// pointer, backing memory, load counters and result register. Uses wtac_pkg.
`timescale 1ns / 1ps
`include "write_through_associative_cache_top_defines.svh"

module wtac_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  wtac_pkg::ctrl_cmd_t        cmd,
  output wtac_pkg::ctrl_sts_t        sts,
  input  logic                       command,
  input  logic [wtac_pkg::ADDR_W-1:0] address,
  input  logic signed [wtac_pkg::DATA_W-1:0] write_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [wtac_pkg::DATA_W-1:0] read_data,
  output logic                       hit,
  output logic [wtac_pkg::CNT_W-1:0] hit_count,
  output logic [wtac_pkg::CNT_W-1:0] miss_count
);
  import wtac_pkg::*;

  logic                entry_valid [ENTRIES];
  logic [ADDR_W-1:0]   entry_tag   [ENTRIES];
  logic [DATA_W-1:0]   entry_word  [ENTRIES];
  logic [PTR_W-1:0]    ptr;

  logic [DATA_W-1:0]   mem [MEM_WORDS];
  logic [DATA_W-1:0]   mem_rdata;
  logic                mem_we;
  logic [MEM_AW-1:0]   mem_waddr;
  logic [DATA_W-1:0]   mem_wdata;
  logic [MEM_AW-1:0]   clear_addr;

  logic                req_cmd;
  logic [ADDR_W-1:0]   req_addr;
  logic [DATA_W-1:0]   req_wdata;

  logic [CNT_W-1:0]    load_hits;
  logic [CNT_W-1:0]    load_misses;

  logic [ENTRIES-1:0]  match;
  logic                any_hit;
  logic [DATA_W-1:0]   hit_word;
  logic                install;
  logic [DATA_W-1:0]   install_word;
  logic [DATA_W-1:0]   result_word;

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_cmd   <= command;
      req_addr  <= address;
      req_wdata <= $unsigned(write_data);
    end
  end

  // Backing memory: registered read on capture, one write port.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mem_rdata <= mem[address];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_comb begin
    mem_we    = cmd.clear_en || (cmd.commit && req_cmd == CMD_STORE);
    mem_waddr = cmd.clear_en ? clear_addr : req_addr;
    mem_wdata = cmd.clear_en ? '0 : req_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.clear_en) begin
      clear_addr <= clear_addr + 1'b1;
    end
  end

  // Tag compare across all entries; the lowest matching entry supplies the word.
  always_comb begin
    hit_word = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      match[i] = entry_valid[i] && (entry_tag[i] == req_addr);
      if (match[i]) hit_word = entry_word[i];
    end
    any_hit = |match;
  end

  always_comb begin
    install      = !any_hit;
    install_word = (req_cmd == CMD_STORE) ? req_wdata : mem_rdata;
    if (req_cmd == CMD_STORE) begin
      result_word = '0;
    end else if (any_hit) begin
      result_word = hit_word;
    end else begin
      result_word = mem_rdata;
    end
  end

  // Entry array and replacement pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        entry_valid[i] <= 1'b0;
      end
      ptr <= '0;
    end else if (cmd.commit) begin
      if (install) begin
        entry_valid[ptr] <= 1'b1;
        ptr <= (ptr == PTR_W'(ENTRIES - 1)) ? '0 : PTR_W'(ptr + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (install) begin
        entry_tag[ptr]  <= req_addr;
        entry_word[ptr] <= install_word;
      end else if (req_cmd == CMD_STORE) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (match[i]) entry_word[i] <= req_wdata;
        end
      end
    end
  end

  // Load counters, which also serve as the count fields of the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      load_hits   <= '0;
      load_misses <= '0;
    end else if (cmd.commit && req_cmd == CMD_LOAD) begin
      if (any_hit) begin
        load_hits <= load_hits + 1'b1;
      end else begin
        load_misses <= load_misses + 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      read_data <= $signed(result_word);
      hit       <= any_hit;
    end
  end

  assign hit_count      = load_hits;
  assign miss_count     = load_misses;
  assign sts.clear_last = (clear_addr == MEM_AW'(MEM_WORDS - 1));
  assign sts.out_stall  = out_valid && !out_ready;

  `WTAC_ASSERT_NEXT(a_commit_fills_output, cmd.commit, out_valid, "committed result not presented")
  `WTAC_ASSERT_NEXT(a_store_hit_keeps_ptr, cmd.commit && req_cmd == CMD_STORE && any_hit, $stable(ptr), "pointer moved on a store hit")
  `WTAC_ASSERT_NEXT(a_load_counts_once, cmd.commit && req_cmd == CMD_LOAD, CNT_W'(load_hits + load_misses) == CNT_W'($past(load_hits) + $past(load_misses) + 1'b1), "load not counted exactly once")

endmodule

// ===== hdl/write_through_associative_cache_top.sv =====
// Top level of the write-through, fully associative cache with round-robin replacement.
// Depends on wtac_pkg, wtac_ctrl and wtac_dp.
`timescale 1ns / 1ps

// How to use this block.
// Requests arrive on the input channel (in_valid / in_ready) as one beat holding
// command (0 = load, 1 = store), a word address and, for stores, write_data.
// Every request yields exactly one result beat on the output channel
// (out_valid / out_ready): read_data (the word on a load, zero on a store), hit,
// and the running load hit and miss counts including this request.
// A request accepted at one clock edge is looked up in the following cycle; its
// result is registered when that lookup commits, which sets out_valid. The next
// request may be accepted as soon as that result is registered, and not before,
// even if the result still waits for the receiver. Each request passes through the
// synchronous backing-memory read, issued at acceptance, and then the lookup in
// which all eight tags are compared and the state is updated.
// When the receiver stalls, the result waits in the output register; a new
// request is still taken, but its lookup holds until the old result is taken.
// After reset the 1024-word backing memory is swept to zero, one word a cycle;
// in_ready stays low until the sweep is done. Entries, replacement pointer and
// counters are cleared by reset itself.
module write_through_associative_cache_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               command,
  input  logic [wtac_pkg::ADDR_W-1:0]        address,
  input  logic signed [wtac_pkg::DATA_W-1:0] write_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [wtac_pkg::DATA_W-1:0] read_data,
  output logic                               hit,
  output logic [wtac_pkg::CNT_W-1:0]         hit_count,
  output logic [wtac_pkg::CNT_W-1:0]         miss_count
);
  import wtac_pkg::*;

  // Command and status between the controller and the datapath.
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // The controller sequences the clearing sweep, request capture and commit.
  wtac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the entries, the backing memory, the counters and the
  // result register.
  wtac_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .command    (command),
    .address    (address),
    .write_data (write_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_data  (read_data),
    .hit        (hit),
    .hit_count  (hit_count),
    .miss_count (miss_count)
  );

endmodule

// ===== bench/cache_result_checker.sv =====
// Checker for the write-through associative cache: predicts every result beat
// and compares it with the block's output. Depends on wtac_pkg only.
`timescale 1ns / 1ps

module cache_result_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic                               command,
  input  logic [wtac_pkg::ADDR_W-1:0]        address,
  input  logic signed [wtac_pkg::DATA_W-1:0] write_data,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [wtac_pkg::DATA_W-1:0] read_data,
  input  logic                               hit,
  input  logic [wtac_pkg::CNT_W-1:0]         hit_count,
  input  logic [wtac_pkg::CNT_W-1:0]         miss_count,
  output int                                 mismatch_count,
  output int                                 outstanding
);
  import wtac_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_data;
    logic                     hit;
    logic [CNT_W-1:0]         hit_count;
    logic [CNT_W-1:0]         miss_count;
  } cache_result_t;

  cache_result_t awaited_results[$];

  logic             line_valid [ENTRIES];
  logic [ADDR_W-1:0] line_tag  [ENTRIES];
  logic [DATA_W-1:0] line_word [ENTRIES];
  logic [PTR_W-1:0]  fill_ptr;
  logic [DATA_W-1:0] mem_image [MEM_WORDS];
  logic [CNT_W-1:0]  load_hit_total;
  logic [CNT_W-1:0]  load_miss_total;

  task automatic clear_model();
    for (int i = 0; i < ENTRIES; i++) begin
      line_valid[i] = 1'b0;
      line_tag[i]   = '0;
      line_word[i]  = '0;
    end
    for (int j = 0; j < MEM_WORDS; j++) begin
      mem_image[j] = '0;
    end
    fill_ptr        = '0;
    load_hit_total  = '0;
    load_miss_total = '0;
    awaited_results.delete();
  endtask

  function automatic void install_line(input logic [ADDR_W-1:0] tag,
                                       input logic [DATA_W-1:0] word);
    line_valid[fill_ptr] = 1'b1;
    line_tag[fill_ptr]   = tag;
    line_word[fill_ptr]  = word;
    fill_ptr = (fill_ptr == PTR_W'(ENTRIES - 1)) ? '0 : fill_ptr + 1'b1;
  endfunction

  // Applies one access to the model and returns the result it should give.
  function automatic cache_result_t predict_cache_access(input logic cmd,
                                                         input logic [ADDR_W-1:0] addr,
                                                         input logic [DATA_W-1:0] wdata);
    cache_result_t     res;
    logic              found;
    logic [DATA_W-1:0] word;
    logic [ADDR_W-1:0] idx;
    found = 1'b0;
    word  = '0;
    idx   = ADDR_W'(addr % MEM_WORDS);
    if (cmd == CMD_LOAD) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (!found && line_valid[i] && line_tag[i] == idx) begin
          found = 1'b1;
          word  = line_word[i];
        end
      end
      if (found) begin
        load_hit_total = load_hit_total + 1'b1;
      end else begin
        load_miss_total = load_miss_total + 1'b1;
        word = mem_image[idx];
        install_line(idx, word);
      end
    end else begin
      mem_image[idx] = wdata;
      for (int i = 0; i < ENTRIES; i++) begin
        if (line_valid[i] && line_tag[i] == idx) begin
          line_word[i] = wdata;
          found = 1'b1;
        end
      end
      if (!found) install_line(idx, wdata);
    end
    res.read_data  = word;
    res.hit        = found;
    res.hit_count  = load_hit_total;
    res.miss_count = load_miss_total;
    return res;
  endfunction

  always @(posedge clk) begin
    cache_result_t want;
    if (rst) begin
      clear_model();
    end else begin
      if (in_valid && in_ready) begin
        awaited_results.push_back(predict_cache_access(command, address, write_data));
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result beat with no request outstanding");
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          if (read_data !== want.read_data) begin
            $error("read_data: expected %0d, got %0d", want.read_data, read_data);
            mismatch_count++;
          end
          if (hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, hit);
            mismatch_count++;
          end
          if (hit_count !== want.hit_count) begin
            $error("hit_count: expected %0d, got %0d", want.hit_count, hit_count);
            mismatch_count++;
          end
          if (miss_count !== want.miss_count) begin
            $error("miss_count: expected %0d, got %0d", want.miss_count, miss_count);
            mismatch_count++;
          end
        end
      end
    end
    outstanding = awaited_results.size();
  end

endmodule

// ===== bench/tb_write_through_associative_cache_top.sv =====
// Top of the bench for the write-through associative cache: clock, reset,
// stimulus, back-pressure and the verdict. Depends on wtac_pkg, the block and
// cache_result_checker.
`timescale 1ns / 1ps

module tb_write_through_associative_cache_top;
  import wtac_pkg::*;

  // After reset the block sweeps its 1024-word memory before taking any beat,
  // and the long receiver hold-off also passes with no accepted beat, yet the
  // stall limit is far above any correct run.
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 60;
  localparam int PHASE_ITEMS  = 345;
  localparam int SETTLE_CYCLES = 20;

  logic                     clk        = 1'b0;
  logic                     rst        = 1'b1;
  logic                     in_valid   = 1'b0;
  logic                     in_ready;
  logic                     command    = CMD_LOAD;
  logic [ADDR_W-1:0]        address    = '0;
  logic signed [DATA_W-1:0] write_data = '0;
  logic                     out_valid;
  logic                     out_ready  = 1'b0;
  logic signed [DATA_W-1:0] read_data;
  logic                     hit;
  logic [CNT_W-1:0]         hit_count;
  logic [CNT_W-1:0]         miss_count;

  int mismatch_count;
  int outstanding;

  // Idle percentages for the two sides, changed by the stimulus between phases.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Long receiver hold-off: requested by the stimulus, counted by the receiver.
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;
  int   hold_cnt  = 0;

  int stall_cycles = 0;

  write_through_associative_cache_top uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .address    (address),
    .write_data (write_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_data  (read_data),
    .hit        (hit),
    .hit_count  (hit_count),
    .miss_count (miss_count)
  );

  cache_result_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .address        (address),
    .write_data     (write_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .read_data      (read_data),
    .hit            (hit),
    .hit_count      (hit_count),
    .miss_count     (miss_count),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Receiver. Normally it drops out_ready at random; once the stimulus asks,
  // it holds off for a fixed stretch so that the output register stays full,
  // the block takes one more request and then has to stall its input.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: any accepted beat on either side clears the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Offers one request beat and returns just after the edge that accepted it.
  // Valid is only ever raised here and held until in_ready is seen high at an
  // edge, so the payload cannot change under a pending beat.
  task automatic send_beat(input logic cmd, input logic [ADDR_W-1:0] addr,
                           input logic signed [DATA_W-1:0] data);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    address    <= addr;
    write_data <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stops offering and waits until every predicted result has been taken.
  // The first edge lets the checker record a beat accepted at the last edge.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    logic                     cmd;
    logic [ADDR_W-1:0]        addr;
    logic signed [DATA_W-1:0] data;
    logic signed [DATA_W-1:0] last_data;
    logic [ADDR_W-1:0]        hot_base;
    int                       pick;

    last_data = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The very first load of address zero must miss, since the
    // entries come out of reset with clear valid bits.
    send_beat(CMD_LOAD, 10'd0, 32'sd0);
    send_beat(CMD_LOAD, 10'd0, 32'sh5a5a5a5a);     // a hit on the line just installed; write data ignored
    send_beat(CMD_STORE, 10'd1023, 32'sh7fffffff); // store miss installs a line
    send_beat(CMD_LOAD, 10'd1023, 32'sd0);
    send_beat(CMD_STORE, 10'd1023, 32'sh80000000); // store hit updates in place
    send_beat(CMD_STORE, 10'd1023, 32'sh80000000); // same data again, no duplicate
    send_beat(CMD_LOAD, 10'd1023, -32'sd1);
    // Fill the remaining lines and carry on so that the pointer wraps round
    // and the oldest lines are evicted.
    for (int i = 1; i <= 7; i++) begin
      send_beat(CMD_LOAD, ADDR_W'(i), 32'sd0);
    end
    send_beat(CMD_LOAD, 10'd0, 32'sd0);            // evicted, misses again
    send_beat(CMD_STORE, 10'd1023, -32'sd1);       // evicted too, store miss
    send_beat(CMD_LOAD, 10'd1023, 32'sd0);
    send_beat(CMD_STORE, 10'd682, 32'sh55555555);
    send_beat(CMD_STORE, 10'd341, 32'shaaaaaaaa);
    send_beat(CMD_LOAD, 10'd682, 32'sd0);
    send_beat(CMD_LOAD, 10'd2, 32'sd0);
    drain_results();

    // Random part in three phases: sender mostly busy with a slow receiver,
    // then the reverse, then no idling at all. Most addresses come from a
    // small window a little larger than the cache, so that hits, store hits
    // and evictions all happen often; the rest span the whole address space.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct <= (ph == 0) ? 24 : (ph == 1) ? 72 : 0;
      recv_idle_pct <= (ph == 0) ? 72 : (ph == 1) ? 24 : 0;
      hot_base = ADDR_W'($urandom);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // With no sender gaps, the long hold-off makes the block back up.
        if (ph == 2 && n == 40) hold_req <= 1'b1;
        cmd = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 65) begin
          addr = hot_base + ADDR_W'($urandom_range(0, 11));
        end else begin
          addr = ADDR_W'($urandom);
        end
        pick = $urandom_range(0, 19);
        case (pick)
          0: data = '0;
          1: data = -32'sd1;
          2: data = 32'sh80000000;
          3: data = 32'sh7fffffff;
          4, 5: data = last_data;
          default: data = $urandom;
        endcase
        last_data = data;
        send_beat(cmd, addr, data);
      end
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
